// ===== design/cise_pkg.sv =====
// package for the cpu instruction subset executor
// holds request modes, opcodes, sequencer states, reset values and the queue word type
package cise_pkg;

   typedef enum logic [1:0] {
      MODE_EXEC  = 2'd0,
      MODE_WRITE = 2'd1,
      MODE_READ  = 2'd2,
      MODE_NONE  = 2'd3
   } mode_type;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_BOOT, ST_IDLE, ST_FETCH, ST_DECODE, ST_IMM1, ST_IMM2,
      ST_OPER, ST_WR1, ST_WR2, ST_DONE
   } state_type;

   localparam logic [7:0] OP_NOP    = 8'h00;
   localparam logic [7:0] OP_LDBCA  = 8'h02;
   localparam logic [7:0] OP_LDDEA  = 8'h12;
   localparam logic [7:0] OP_LDNNSP = 8'h08;
   localparam logic [7:0] OP_LDHLN  = 8'h36;
   localparam logic [7:0] OP_HALT   = 8'h76;
   localparam logic [7:0] OP_LDNNA  = 8'hEA;

   // pair opcode families: ld rr,nn and inc rr
   localparam logic [7:0] OP_MASK_PAIR = 8'hCF;
   localparam logic [7:0] OP_LDRRNN    = 8'h01;
   localparam logic [7:0] OP_INCRR     = 8'h03;

   // 8-bit operand index that selects the byte at (hl)
   localparam logic [2:0] REG_MEM = 3'd6;

   localparam logic [15:0] RST_AF = 16'h01B0;
   localparam logic [15:0] RST_BC = 16'h0013;
   localparam logic [15:0] RST_DE = 16'h00D8;
   localparam logic [15:0] RST_HL = 16'h014D;
   localparam logic [15:0] RST_SP = 16'hFFFE;
   localparam logic [15:0] RST_PC = 16'h0100;

   localparam int BOOT_N = 31;

   typedef struct packed {
      mode_type    mode;
      logic [15:0] address;
      logic [7:0]  write_data;
   } word_type;

   typedef struct packed {
      logic [15:0] address;
      logic [7:0]  value;
   } boot_type;

   function automatic boot_type boot_entry(input logic [4:0] i);
      case (i)
         5'd0:  boot_entry = '{16'hFF05, 8'h00};
         5'd1:  boot_entry = '{16'hFF06, 8'h00};
         5'd2:  boot_entry = '{16'hFF07, 8'h00};
         5'd3:  boot_entry = '{16'hFF10, 8'h80};
         5'd4:  boot_entry = '{16'hFF11, 8'hBF};
         5'd5:  boot_entry = '{16'hFF12, 8'hF3};
         5'd6:  boot_entry = '{16'hFF14, 8'hBF};
         5'd7:  boot_entry = '{16'hFF16, 8'h3F};
         5'd8:  boot_entry = '{16'hFF17, 8'h00};
         5'd9:  boot_entry = '{16'hFF19, 8'hBF};
         5'd10: boot_entry = '{16'hFF1A, 8'h7F};
         5'd11: boot_entry = '{16'hFF1B, 8'hFF};
         5'd12: boot_entry = '{16'hFF1C, 8'h9F};
         5'd13: boot_entry = '{16'hFF1E, 8'hBF};
         5'd14: boot_entry = '{16'hFF20, 8'hFF};
         5'd15: boot_entry = '{16'hFF21, 8'h00};
         5'd16: boot_entry = '{16'hFF22, 8'h00};
         5'd17: boot_entry = '{16'hFF23, 8'hBF};
         5'd18: boot_entry = '{16'hFF24, 8'h77};
         5'd19: boot_entry = '{16'hFF25, 8'hF3};
         5'd20: boot_entry = '{16'hFF26, 8'hF1};
         5'd21: boot_entry = '{16'hFF40, 8'h91};
         5'd22: boot_entry = '{16'hFF42, 8'h00};
         5'd23: boot_entry = '{16'hFF43, 8'h00};
         5'd24: boot_entry = '{16'hFF45, 8'h00};
         5'd25: boot_entry = '{16'hFF47, 8'hFC};
         5'd26: boot_entry = '{16'hFF48, 8'hFF};
         5'd27: boot_entry = '{16'hFF49, 8'hFF};
         5'd28: boot_entry = '{16'hFF4A, 8'h00};
         5'd29: boot_entry = '{16'hFF4B, 8'h00};
         default: boot_entry = '{16'hFFFF, 8'h00};
      endcase
   endfunction

endpackage

// ===== design/cpu_instruction_subset_executor.sv =====
// executes one instruction, memory write or memory read per request word
// writes, halted executes and mode none respond from idle; reads pass through done,
// and instructions through opcode fetch, operand fetches and writes on single-port
// byte memory; a two-word queue decouples the request port and registers each word
// reset: synchronous; memory is cleared one byte a cycle
// then 31 power-up bytes are written before the first request is taken
module cpu_instruction_subset_executor import cise_pkg::*; #(
   parameter int MEM_BYTES = 65536
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_mode,
   input  logic [15:0] req_address,
   input  logic [7:0]  req_write_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_read_data,
   output logic [15:0] rsp_pc_out,
   output logic [15:0] rsp_sp_out,
   output logic [15:0] rsp_af_out,
   output logic [15:0] rsp_bc_out,
   output logic [15:0] rsp_de_out,
   output logic [15:0] rsp_hl_out,
   output logic [31:0] rsp_cycle_total,
   output logic        rsp_halted,
   output logic        rsp_unknown_opcode
);

   word_type in_word, q_word;
   logic     q_valid, q_ready;

   assign in_word = '{mode: mode_type'(req_mode), address: req_address,
                      write_data: req_write_data};

   cise_queue u_queue (
      .clock, .reset,
      .in_valid (req_valid), .in_ready (req_ready), .in_word (in_word),
      .out_valid (q_valid), .out_ready (q_ready), .out_word (q_word)
   );

   cise_exec #(.MEM_BYTES(MEM_BYTES)) u_exec (
      .clock, .reset,
      .word_valid (q_valid), .word_ready (q_ready), .word (q_word),
      .rsp_valid, .rsp_ready, .rsp_read_data, .rsp_pc_out, .rsp_sp_out,
      .rsp_af_out, .rsp_bc_out, .rsp_de_out, .rsp_hl_out, .rsp_cycle_total,
      .rsp_halted, .rsp_unknown_opcode
   );

endmodule

// ===== design/cise_queue.sv =====
// front end: two-entry word queue between request port and executor
// depends on cise_pkg
module cise_queue import cise_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  word_type in_word,
   output logic     out_valid,
   input  logic     out_ready,
   output word_type out_word
);

   word_type   mem_ff [2];
   word_type   mem_in;
   logic       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_word  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign mem_in    = in_word;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= mem_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== design/cise_exec.sv =====
// back end: sequencer, register file and single-port byte memory
// depends on cise_pkg
module cise_exec import cise_pkg::*; #(
   parameter int MEM_BYTES = 65536
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        word_valid,
   output logic        word_ready,
   input  word_type    word,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_read_data,
   output logic [15:0] rsp_pc_out,
   output logic [15:0] rsp_sp_out,
   output logic [15:0] rsp_af_out,
   output logic [15:0] rsp_bc_out,
   output logic [15:0] rsp_de_out,
   output logic [15:0] rsp_hl_out,
   output logic [31:0] rsp_cycle_total,
   output logic        rsp_halted,
   output logic        rsp_unknown_opcode
);

   localparam int AW = $clog2(MEM_BYTES);

   state_type   state_ff, state_in;
   logic [7:0]  mem [MEM_BYTES];
   logic [AW:0] clr_ff, clr_in;
   logic [4:0]  boot_ff, boot_in;
   logic [7:0]  rdata_ff;

   logic [15:0] af_ff, af_in, bc_ff, bc_in, de_ff, de_in, hl_ff, hl_in;
   logic [15:0] sp_ff, sp_in, pc_ff, pc_in;
   logic [31:0] cyc_ff, cyc_in;
   logic        halt_ff, halt_in;
   logic [7:0]  op_ff, op_in, lo_ff, lo_in, hi_ff, hi_in;
   word_type    cur_ff, cur_in;
   logic        valid_ff, valid_in, unk_ff, unk_in;
   logic [7:0]  rd_ff, rd_in;

   // memory port control
   logic        mem_we, mem_re;
   logic [15:0] mem_addr;
   logic [7:0]  mem_wdata;

   logic [2:0]  dst, src;
   logic [7:0]  src_val, old_val, inc_val, dec_val;
   logic        is_ld, is_incdec, is_ldrr, is_incrr, is_dec, hl_oper;
   logic        slot_free;

   assign dst       = op_ff[5:3];
   assign src       = op_ff[2:0];
   assign is_ld     = (op_ff[7:6] == 2'b01) && (op_ff != OP_HALT);
   assign is_incdec = (op_ff[7:6] == 2'b00) && (op_ff[2:1] == 2'b10);
   assign is_dec    = op_ff[0];
   assign is_ldrr   = (op_ff & OP_MASK_PAIR) == OP_LDRRNN;
   assign is_incrr  = (op_ff & OP_MASK_PAIR) == OP_INCRR;
   assign hl_oper   = (is_ld && (src == REG_MEM)) || (is_incdec && (dst == REG_MEM));
   assign slot_free = !valid_ff || rsp_ready;
   assign word_ready = (state_ff == ST_IDLE) && slot_free;

   function automatic logic [7:0] get_reg(input logic [2:0] r, input logic [7:0] m,
         input logic [15:0] bc, input logic [15:0] de, input logic [15:0] hl,
         input logic [15:0] af);
      case (r)
         3'd0: get_reg = bc[15:8];
         3'd1: get_reg = bc[7:0];
         3'd2: get_reg = de[15:8];
         3'd3: get_reg = de[7:0];
         3'd4: get_reg = hl[15:8];
         3'd5: get_reg = hl[7:0];
         REG_MEM: get_reg = m;
         default: get_reg = af[15:8];
      endcase
   endfunction

   assign src_val = get_reg(src, rdata_ff, bc_ff, de_ff, hl_ff, af_ff);
   assign old_val = get_reg(dst, rdata_ff, bc_ff, de_ff, hl_ff, af_ff);
   assign inc_val = old_val + 8'd1;
   assign dec_val = old_val - 8'd1;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr[AW-1:0]] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= mem[mem_addr[AW-1:0]];
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:  if (clr_ff == (AW+1)'(MEM_BYTES - 1)) state_in = ST_BOOT;
         ST_BOOT:   if (boot_ff == 5'(BOOT_N - 1)) state_in = ST_IDLE;
         ST_IDLE: begin
            if (word_valid && slot_free) begin
               if (word.mode == MODE_EXEC && !halt_ff) state_in = ST_FETCH;
               else if (word.mode == MODE_READ) state_in = ST_DONE;
               else state_in = ST_IDLE;
            end
         end
         ST_FETCH:  state_in = ST_DECODE;
         ST_DECODE: begin
            if (is_ldrr || op_ff == OP_LDNNSP || op_ff == OP_LDNNA
                  || op_ff == OP_LDHLN) state_in = ST_IMM1;
            else if (hl_oper)
               state_in = ST_OPER;
            else state_in = ST_DONE;
         end
         ST_IMM1: begin
            if (op_ff == OP_LDHLN) state_in = ST_WR1;
            else state_in = ST_IMM2;
         end
         ST_IMM2:   state_in = (is_ldrr) ? ST_DONE : ST_WR1;
         ST_OPER:   state_in = ST_DONE;
         ST_WR1:    state_in = (op_ff == OP_LDNNSP) ? ST_WR2 : ST_DONE;
         ST_WR2:    state_in = ST_DONE;
         ST_DONE:   state_in = slot_free ? ST_IDLE : ST_DONE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      logic [15:0] nn;
      logic [7:0]  res;
      logic [7:0]  f;
      boot_type    be;
      nn        = {hi_ff, lo_ff};
      res       = 8'd0;
      f         = af_ff[7:0];
      be        = boot_entry(boot_ff);
      clr_in    = clr_ff;
      boot_in   = boot_ff;
      af_in = af_ff; bc_in = bc_ff; de_in = de_ff; hl_in = hl_ff;
      sp_in = sp_ff; pc_in = pc_ff; cyc_in = cyc_ff; halt_in = halt_ff;
      op_in = op_ff; lo_in = lo_ff; hi_in = hi_ff; cur_in = cur_ff;
      valid_in  = valid_ff && !rsp_ready;
      unk_in    = unk_ff;
      rd_in     = rd_ff;
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      mem_addr  = 16'd0;
      mem_wdata = 8'd0;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_we   = 1'b1;
            mem_addr = 16'(clr_ff);
            clr_in   = clr_ff + 1'b1;
         end
         ST_BOOT: begin
            mem_we    = 1'b1;
            mem_addr  = be.address;
            mem_wdata = be.value;
            boot_in   = boot_ff + 5'd1;
         end
         ST_IDLE: begin
            if (word_valid && slot_free) begin
               cur_in = word;
               unk_in = 1'b0;
               rd_in  = 8'd0;
               unique case (word.mode)
                  MODE_EXEC: begin
                     if (halt_ff) begin
                        cyc_in   = cyc_ff + 32'd4;
                        valid_in = 1'b1;
                     end else begin
                        mem_re   = 1'b1;
                        mem_addr = pc_ff;
                     end
                  end
                  MODE_WRITE: begin
                     mem_we    = 1'b1;
                     mem_addr  = word.address;
                     mem_wdata = word.write_data;
                     valid_in  = 1'b1;
                  end
                  MODE_READ: begin
                     mem_re   = 1'b1;
                     mem_addr = word.address;
                  end
                  default: valid_in = 1'b1;
               endcase
            end
         end
         ST_FETCH: begin
            op_in    = rdata_ff;
            // prefetch (hl) for the operand forms
            mem_re   = 1'b1;
            mem_addr = hl_ff;
         end
         ST_DECODE: begin
            // operand forms keep (hl) in the read register for oper
            mem_re   = 1'b1;
            mem_addr = hl_oper ? hl_ff : pc_ff + 16'd1;
            if (op_ff == OP_HALT) begin
               halt_in = 1'b1;
               pc_in   = pc_ff + 16'd1;
               cyc_in  = cyc_ff + 32'd4;
            end else if (is_ld) begin
               if (src != REG_MEM) begin
                  res = src_val;
                  if (dst == REG_MEM) begin
                     mem_we = 1'b1; mem_re = 1'b0;
                     mem_addr = hl_ff; mem_wdata = res;
                  end
                  case (dst)
                     3'd0: bc_in[15:8] = res;
                     3'd1: bc_in[7:0]  = res;
                     3'd2: de_in[15:8] = res;
                     3'd3: de_in[7:0]  = res;
                     3'd4: hl_in[15:8] = res;
                     3'd5: hl_in[7:0]  = res;
                     REG_MEM: ;
                     default: af_in[15:8] = res;
                  endcase
                  pc_in  = pc_ff + 16'd1;
                  cyc_in = cyc_ff + ((dst == REG_MEM) ? 32'd8 : 32'd4);
               end
            end else if (is_incdec) begin
               if (dst != REG_MEM) begin
                  res = is_dec ? dec_val : inc_val;
                  case (dst)
                     3'd0: bc_in[15:8] = res;
                     3'd1: bc_in[7:0]  = res;
                     3'd2: de_in[15:8] = res;
                     3'd3: de_in[7:0]  = res;
                     3'd4: hl_in[15:8] = res;
                     3'd5: hl_in[7:0]  = res;
                     default: af_in[15:8] = res;
                  endcase
                  f[7] = (res == 8'd0);
                  f[6] = is_dec;
                  f[5] = is_dec ? (old_val[3:0] == 4'h0) : (old_val[3:0] == 4'hF);
                  if (dst == 3'd7) af_in = {res, f};
                  else af_in[7:0] = f;
                  pc_in  = pc_ff + 16'd1;
                  cyc_in = cyc_ff + 32'd4;
               end
            end else if (is_incrr) begin
               case (op_ff[5:4])
                  2'd0: bc_in = bc_ff + 16'd1;
                  2'd1: de_in = de_ff + 16'd1;
                  2'd2: hl_in = hl_ff + 16'd1;
                  default: sp_in = sp_ff + 16'd1;
               endcase
               pc_in  = pc_ff + 16'd1;
               cyc_in = cyc_ff + 32'd8;
            end else if (op_ff == OP_LDBCA || op_ff == OP_LDDEA) begin
               mem_we = 1'b1; mem_re = 1'b0;
               mem_addr  = (op_ff == OP_LDBCA) ? bc_ff : de_ff;
               mem_wdata = af_ff[15:8];
               pc_in  = pc_ff + 16'd1;
               cyc_in = cyc_ff + 32'd8;
            end else if (is_ldrr || op_ff == OP_LDNNSP || op_ff == OP_LDNNA
                  || op_ff == OP_LDHLN) begin
               // operand bytes follow
            end else begin
               unk_in = (op_ff != OP_NOP);
               pc_in  = pc_ff + 16'd1;
               cyc_in = cyc_ff + 32'd4;
            end
         end
         ST_IMM1: begin
            lo_in    = rdata_ff;
            mem_re   = 1'b1;
            mem_addr = pc_ff + 16'd2;
         end
         ST_IMM2: begin
            hi_in = rdata_ff;
            if (is_ldrr) begin
               case (op_ff[5:4])
                  2'd0: bc_in = {rdata_ff, lo_ff};
                  2'd1: de_in = {rdata_ff, lo_ff};
                  2'd2: hl_in = {rdata_ff, lo_ff};
                  default: sp_in = {rdata_ff, lo_ff};
               endcase
               pc_in  = pc_ff + 16'd3;
               cyc_in = cyc_ff + 32'd12;
            end
         end
         ST_OPER: begin
            if (is_ld) begin
               res = rdata_ff;
               case (dst)
                  3'd0: bc_in[15:8] = res;
                  3'd1: bc_in[7:0]  = res;
                  3'd2: de_in[15:8] = res;
                  3'd3: de_in[7:0]  = res;
                  3'd4: hl_in[15:8] = res;
                  3'd5: hl_in[7:0]  = res;
                  default: af_in[15:8] = res;
               endcase
               pc_in  = pc_ff + 16'd1;
               cyc_in = cyc_ff + 32'd8;
            end else begin
               res = is_dec ? dec_val : inc_val;
               mem_we = 1'b1; mem_addr = hl_ff; mem_wdata = res;
               f[7] = (res == 8'd0);
               f[6] = is_dec;
               f[5] = is_dec ? (old_val[3:0] == 4'h0) : (old_val[3:0] == 4'hF);
               af_in[7:0] = f;
               pc_in  = pc_ff + 16'd1;
               cyc_in = cyc_ff + 32'd12;
            end
         end
         ST_WR1: begin
            mem_we = 1'b1;
            if (op_ff == OP_LDHLN) begin
               mem_addr = hl_ff; mem_wdata = lo_ff;
               pc_in  = pc_ff + 16'd2;
               cyc_in = cyc_ff + 32'd12;
            end else if (op_ff == OP_LDNNA) begin
               mem_addr = nn; mem_wdata = af_ff[15:8];
               pc_in  = pc_ff + 16'd3;
               cyc_in = cyc_ff + 32'd16;
            end else begin
               mem_addr = nn; mem_wdata = sp_ff[7:0];
            end
         end
         ST_WR2: begin
            mem_we = 1'b1; mem_addr = nn + 16'd1; mem_wdata = sp_ff[15:8];
            pc_in  = pc_ff + 16'd3;
            cyc_in = cyc_ff + 32'd20;
         end
         ST_DONE: begin
            if (slot_free) begin
               valid_in = 1'b1;
               if (cur_ff.mode == MODE_READ) rd_in = rdata_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      cur_ff <= cur_in;
      rd_ff  <= rd_in;
      unk_ff <= unk_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         boot_ff  <= 5'd0;
         af_ff <= RST_AF; bc_ff <= RST_BC; de_ff <= RST_DE; hl_ff <= RST_HL;
         sp_ff <= RST_SP; pc_ff <= RST_PC;
         cyc_ff   <= 32'd0;
         halt_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         boot_ff  <= boot_in;
         af_ff <= af_in; bc_ff <= bc_in; de_ff <= de_in; hl_ff <= hl_in;
         sp_ff <= sp_in; pc_ff <= pc_in;
         cyc_ff   <= cyc_in;
         halt_ff  <= halt_in;
         valid_ff <= valid_in;
      end
   end

   // the result register captures the next state whenever a new response is loaded
   logic [15:0] s_pc, s_sp, s_af, s_bc, s_de, s_hl;
   logic [31:0] s_cyc;
   logic        s_halt;
   always_ff @(posedge clock) begin
      if (valid_in && (!valid_ff || rsp_ready)) begin
         s_pc <= pc_in; s_sp <= sp_in; s_af <= af_in; s_bc <= bc_in;
         s_de <= de_in; s_hl <= hl_in; s_cyc <= cyc_in; s_halt <= halt_in;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_read_data      = rd_ff;
   assign rsp_pc_out         = s_pc;
   assign rsp_sp_out         = s_sp;
   assign rsp_af_out         = s_af;
   assign rsp_bc_out         = s_bc;
   assign rsp_de_out         = s_de;
   assign rsp_hl_out         = s_hl;
   assign rsp_cycle_total    = s_cyc;
   assign rsp_halted         = s_halt;
   assign rsp_unknown_opcode = unk_ff;

endmodule

// ===== tb/cpu_instruction_subset_executor_tb.sv =====
// self-checking testbench for cpu_instruction_subset_executor
// depends on cise_pkg and the executor rtl; predicts every response word in-house
`timescale 1ns / 100ps

module cpu_instruction_subset_executor_tb;
   import cise_pkg::*;

   localparam int LIMIT_CYCLES = 1000000;
   localparam int ITEM_TARGET  = 950;
   localparam int PAUSE_AT     = 300;
   localparam int HOLD_AT      = 150;
   localparam int HOLD_CYCLES  = 400;
   localparam int QUIET_LO     = 500;
   localparam int QUIET_HI     = 620;

   localparam logic [7:0] FAM_MASK_R  = 8'hC7;
   localparam logic [7:0] FAM_MASK_P  = 8'hCF;
   localparam logic [7:0] FAM_INC_R   = 8'h04;
   localparam logic [7:0] FAM_DEC_R   = 8'h05;
   localparam logic [7:0] FAM_LD_RR   = 8'h01;
   localparam logic [7:0] FAM_INC_RR  = 8'h03;
   localparam logic [7:0] OP_LD_FIRST = 8'h40;
   localparam logic [7:0] OP_LD_LAST  = 8'h7F;
   localparam logic [7:0] OP_ALIEN    = 8'hCB;
   localparam logic [7:0] FLAG_Z = 8'h80;
   localparam logic [7:0] FLAG_N = 8'h40;
   localparam logic [7:0] FLAG_H = 8'h20;
   localparam logic [2:0] IDX_MEM = 3'd6;

   localparam logic [15:0] PWR_ADDR [31] = '{
      16'hFF05, 16'hFF06, 16'hFF07, 16'hFF10, 16'hFF11, 16'hFF12, 16'hFF14, 16'hFF16,
      16'hFF17, 16'hFF19, 16'hFF1A, 16'hFF1B, 16'hFF1C, 16'hFF1E, 16'hFF20, 16'hFF21,
      16'hFF22, 16'hFF23, 16'hFF24, 16'hFF25, 16'hFF26, 16'hFF40, 16'hFF42, 16'hFF43,
      16'hFF45, 16'hFF47, 16'hFF48, 16'hFF49, 16'hFF4A, 16'hFF4B, 16'hFFFF};
   localparam logic [7:0] PWR_VAL [31] = '{
      8'h00, 8'h00, 8'h00, 8'h80, 8'hBF, 8'hF3, 8'hBF, 8'h3F,
      8'h00, 8'hBF, 8'h7F, 8'hFF, 8'h9F, 8'hBF, 8'hFF, 8'h00,
      8'h00, 8'hBF, 8'h77, 8'hF3, 8'hF1, 8'h91, 8'h00, 8'h00,
      8'h00, 8'hFC, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00};

   typedef struct {
      logic [7:0]  read_data;
      logic [15:0] pc, sp, af, bc, de, hl;
      logic [31:0] cycles;
      logic        halted;
      logic        unknown;
   } snapshot_type;

   logic        clock, reset;
   logic        req_valid, req_ready;
   logic [1:0]  req_mode;
   logic [15:0] req_address;
   logic [7:0]  req_write_data;
   logic        rsp_valid, rsp_ready;
   logic [7:0]  rsp_read_data;
   logic [15:0] rsp_pc_out, rsp_sp_out, rsp_af_out, rsp_bc_out, rsp_de_out, rsp_hl_out;
   logic [31:0] rsp_cycle_total;
   logic        rsp_halted, rsp_unknown_opcode;

   cpu_instruction_subset_executor i_dut (.*);

   // cpu state as the core should see it
   logic [7:0]  cpu_mem [0:65535];
   logic [15:0] cpu_af, cpu_bc, cpu_de, cpu_hl, cpu_sp, cpu_pc;
   logic [31:0] cpu_clocks;
   logic        cpu_halt;

   word_type     pending_words [$];
   snapshot_type expected_snaps [$];
   int n_sent, n_got, fail_count, cycle_count, gap_left, hold_left;
   bit held_once, req_fire;

   always begin
      clock = 1'b1; #2;
      clock = 1'b0; #2;
   end

   function automatic logic [7:0] reg8(input logic [2:0] idx);
      case (idx)
         3'd0: return cpu_bc[15:8];
         3'd1: return cpu_bc[7:0];
         3'd2: return cpu_de[15:8];
         3'd3: return cpu_de[7:0];
         3'd4: return cpu_hl[15:8];
         3'd5: return cpu_hl[7:0];
         IDX_MEM: return cpu_mem[cpu_hl];
         default: return cpu_af[15:8];
      endcase
   endfunction

   function automatic void put_reg8(input logic [2:0] idx, input logic [7:0] v);
      case (idx)
         3'd0: cpu_bc[15:8] = v;
         3'd1: cpu_bc[7:0] = v;
         3'd2: cpu_de[15:8] = v;
         3'd3: cpu_de[7:0] = v;
         3'd4: cpu_hl[15:8] = v;
         3'd5: cpu_hl[7:0] = v;
         IDX_MEM: cpu_mem[cpu_hl] = v;
         default: cpu_af[15:8] = v;
      endcase
   endfunction

   function automatic logic [15:0] pair16(input logic [1:0] idx);
      case (idx)
         2'd0: return cpu_bc;
         2'd1: return cpu_de;
         2'd2: return cpu_hl;
         default: return cpu_sp;
      endcase
   endfunction

   function automatic void put_pair16(input logic [1:0] idx, input logic [15:0] v);
      case (idx)
         2'd0: cpu_bc = v;
         2'd1: cpu_de = v;
         2'd2: cpu_hl = v;
         default: cpu_sp = v;
      endcase
   endfunction

   // runs one instruction at pc, returns 1 for an opcode outside the subset
   function automatic bit run_instruction();
      logic [7:0]  op, old, res, fl;
      logic [15:0] nn;
      logic [2:0]  idx;
      int          len, clk;
      bit          unk;
      op  = cpu_mem[cpu_pc];
      nn  = {cpu_mem[16'(cpu_pc + 2)], cpu_mem[16'(cpu_pc + 1)]};
      len = 1;
      clk = 4;
      unk = 0;
      if (op >= OP_LD_FIRST && op <= OP_LD_LAST) begin
         if (op == OP_HALT) begin
            cpu_halt = 1'b1;
         end else begin
            put_reg8(op[5:3], reg8(op[2:0]));
            if (op[5:3] == IDX_MEM || op[2:0] == IDX_MEM) clk = 8;
         end
      end else if ((op & FAM_MASK_R) == FAM_INC_R || (op & FAM_MASK_R) == FAM_DEC_R) begin
         idx = op[5:3];
         old = reg8(idx);
         res = op[0] ? old - 8'd1 : old + 8'd1;
         put_reg8(idx, res);
         fl = cpu_af[7:0] & ~(FLAG_Z | FLAG_N | FLAG_H);
         if (res == 8'd0) fl |= FLAG_Z;
         if (op[0]) fl |= FLAG_N;
         // half carry on inc, half borrow on dec
         if (op[0] ? (old[3:0] == 4'h0) : (old[3:0] == 4'hF)) fl |= FLAG_H;
         cpu_af[7:0] = fl;
         if (idx == IDX_MEM) clk = 12;
      end else if ((op & FAM_MASK_P) == FAM_LD_RR) begin
         put_pair16(op[5:4], nn);
         len = 3;
         clk = 12;
      end else if ((op & FAM_MASK_P) == FAM_INC_RR) begin
         put_pair16(op[5:4], pair16(op[5:4]) + 16'd1);
         clk = 8;
      end else if (op == OP_LDBCA || op == OP_LDDEA) begin
         cpu_mem[op == OP_LDBCA ? cpu_bc : cpu_de] = cpu_af[15:8];
         clk = 8;
      end else if (op == OP_LDNNSP) begin
         cpu_mem[nn] = cpu_sp[7:0];
         cpu_mem[16'(nn + 1)] = cpu_sp[15:8];
         len = 3;
         clk = 20;
      end else if (op == OP_LDHLN) begin
         cpu_mem[cpu_hl] = cpu_mem[16'(cpu_pc + 1)];
         len = 2;
         clk = 12;
      end else if (op == OP_LDNNA) begin
         cpu_mem[nn] = cpu_af[15:8];
         len = 3;
         clk = 16;
      end else if (op != OP_NOP) begin
         unk = 1;
      end
      cpu_pc = cpu_pc + 16'(len);
      cpu_clocks = cpu_clocks + 32'(clk);
      return unk;
   endfunction

   // queues one request word together with the snapshot it must return
   function automatic void issue(input mode_type md, input logic [15:0] a,
                                 input logic [7:0] d);
      snapshot_type s;
      s.read_data = 8'd0;
      s.unknown = 1'b0;
      case (md)
         MODE_EXEC: begin
            if (cpu_halt) cpu_clocks = cpu_clocks + 32'd4;
            else s.unknown = run_instruction();
         end
         MODE_WRITE: cpu_mem[a] = d;
         MODE_READ: s.read_data = cpu_mem[a];
         default: ;
      endcase
      s.pc = cpu_pc;
      s.sp = cpu_sp;
      s.af = cpu_af;
      s.bc = cpu_bc;
      s.de = cpu_de;
      s.hl = cpu_hl;
      s.cycles = cpu_clocks;
      s.halted = cpu_halt;
      pending_words.push_back('{md, a, d});
      expected_snaps.push_back(s);
   endfunction

   // execute at pc, patching out a halt that would freeze the core too early
   function automatic void step_cpu();
      if (cpu_mem[cpu_pc] == OP_HALT) issue(MODE_WRITE, cpu_pc, OP_NOP);
      issue(MODE_EXEC, 16'($urandom), 8'($urandom));
   endfunction

   function automatic void place(input logic [7:0] b0, input logic [7:0] b1,
                                 input logic [7:0] b2, input int len);
      issue(MODE_WRITE, cpu_pc, b0);
      if (len > 1) issue(MODE_WRITE, cpu_pc + 16'd1, b1);
      if (len > 2) issue(MODE_WRITE, cpu_pc + 16'd2, b2);
      step_cpu();
   endfunction

   function automatic logic [15:0] pick_addr();
      case ($urandom_range(0, 3))
         0: return 16'hC000 | 16'($urandom_range(0, 31));
         1: return 16'hFF00 | 16'($urandom_range(0, 255));
         2: return 16'h0100 | 16'($urandom_range(0, 1023));
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic void random_instruction();
      logic [7:0]  op;
      logic [15:0] nn;
      nn = pick_addr();
      case ($urandom_range(0, 9))
         0, 1: op = OP_LD_FIRST | 8'($urandom_range(0, 63));
         2, 3: op = {2'b00, 3'($urandom), 2'b10, 1'($urandom)};
         4: op = {2'b00, 2'($urandom), 4'h1};
         5: op = {2'b00, 2'($urandom), 4'h3};
         6: op = $urandom_range(0, 1) ? OP_LDBCA : OP_LDDEA;
         7: op = $urandom_range(0, 1) ? OP_LDNNSP : OP_LDNNA;
         8: op = OP_LDHLN;
         default: op = 8'($urandom);
      endcase
      if (op == OP_HALT) op = OP_ALIEN;
      if ((op & FAM_MASK_P) == FAM_LD_RR || op == OP_LDNNSP || op == OP_LDNNA)
         place(op, nn[7:0], nn[15:8], 3);
      else if (op == OP_LDHLN)
         place(op, 8'($urandom), 8'd0, 2);
      else
         place(op, 8'd0, 8'd0, 1);
   endfunction

   function automatic void build_stimulus();
      logic [15:0] pc0;
      for (int i = 0; i < 65536; i++) cpu_mem[i] = 8'd0;
      for (int i = 0; i < 31; i++) cpu_mem[PWR_ADDR[i]] = PWR_VAL[i];
      cpu_af = RST_AF; cpu_bc = RST_BC; cpu_de = RST_DE; cpu_hl = RST_HL;
      cpu_sp = RST_SP; cpu_pc = RST_PC; cpu_clocks = 32'd0; cpu_halt = 1'b0;

      // directed: power-up bytes, address/data extremes, all opcode groups but halt, nop, ld (rr),a
      issue(MODE_READ, 16'hFF40, 8'd0);
      issue(MODE_READ, 16'hFFFF, 8'hFF);
      issue(MODE_WRITE, 16'h0000, 8'hFF);
      issue(MODE_READ, 16'h0000, 8'h00);
      issue(MODE_NONE, 16'hFFFF, 8'hFF);
      place(FAM_LD_RR | 8'h30, 8'hFF, 8'hFF, 3);       // ld sp,ffff
      place(FAM_INC_RR | 8'h30, 8'd0, 8'd0, 1);        // inc sp wraps to zero
      place(OP_LDNNSP, 8'hFF, 8'hFF, 3);               // nn+1 wraps to zero
      place(8'h05, 8'd0, 8'd0, 1);                     // dec b: 00 wraps to ff, half borrow
      place(8'h0C, 8'd0, 8'd0, 1);                     // inc c
      place(8'h34, 8'd0, 8'd0, 1);                     // inc (hl)
      place(OP_LDHLN, 8'hFF, 8'd0, 2);
      place(8'h34, 8'd0, 8'd0, 1);                     // ff -> 00 sets z and h
      place(8'h35, 8'd0, 8'd0, 1);
      place(8'h7E, 8'd0, 8'd0, 1);                     // ld a,(hl)
      place(OP_LDNNA, 8'h00, 8'hC0, 3);
      place(OP_ALIEN, 8'd0, 8'd0, 1);
      pc0 = cpu_pc;
      issue(MODE_READ, pc0 - 16'd1, 8'd0);

      // random: mostly well-formed instruction words, some raw execution and noise
      while (pending_words.size() < ITEM_TARGET) begin
         case ($urandom_range(0, 9))
            0: issue(mode_type'($urandom_range(0, 3)), 16'($urandom), 8'($urandom));
            1: issue(MODE_READ, $urandom_range(0, 1) ? cpu_hl : pick_addr(),
                     8'($urandom));
            2: step_cpu();
            default: random_instruction();
         endcase
      end

      // halt, then execution while halted
      issue(MODE_WRITE, cpu_pc, OP_HALT);
      issue(MODE_EXEC, 16'h0000, 8'h00);
      for (int i = 0; i < 4; i++) issue(MODE_EXEC, 16'($urandom), 8'($urandom));
      issue(MODE_WRITE, 16'hFFFF, 8'h5A);
      issue(MODE_READ, 16'hFFFF, 8'h00);
   endfunction

   function automatic int pick_gap();
      int r;
      if (n_sent >= QUIET_LO && n_sent < QUIET_HI) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   always @(posedge clock) req_fire <= !reset && req_valid && req_ready;

   // request driver
   always @(negedge clock) begin
      word_type w;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_fire) n_sent++;
         if (!req_valid || req_fire) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (n_sent == PAUSE_AT && n_got < n_sent) begin
               // drain everything before going on
               req_valid <= 1'b0;
            end else if (pending_words.size() > 0) begin
               w = pending_words.pop_front();
               req_mode <= w.mode;
               req_address <= w.address;
               req_write_data <= w.write_data;
               req_valid <= 1'b1;
               gap_left = pick_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response back-pressure, with one long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (!held_once && n_got >= HOLD_AT) begin
         held_once = 1;
         hold_left = HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (n_sent >= QUIET_LO && n_sent < QUIET_HI) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= (pick_gap() == 0);
      end
   end

   function automatic void check_field(input string name, input logic [31:0] exp_v,
                                       input logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $error("word %0d %s: expected %0h, got %0h", n_got, name, exp_v, act_v);
         fail_count++;
      end
   endfunction

   // response monitor
   always @(posedge clock) begin
      snapshot_type s;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_snaps.size() == 0) begin
            $error("response word with nothing expected");
            fail_count++;
         end else begin
            s = expected_snaps.pop_front();
            check_field("read_data", 32'(s.read_data), 32'(rsp_read_data));
            check_field("pc_out", 32'(s.pc), 32'(rsp_pc_out));
            check_field("sp_out", 32'(s.sp), 32'(rsp_sp_out));
            check_field("af_out", 32'(s.af), 32'(rsp_af_out));
            check_field("bc_out", 32'(s.bc), 32'(rsp_bc_out));
            check_field("de_out", 32'(s.de), 32'(rsp_de_out));
            check_field("hl_out", 32'(s.hl), 32'(rsp_hl_out));
            check_field("cycle_total", s.cycles, rsp_cycle_total);
            check_field("halted", 32'(s.halted), 32'(rsp_halted));
            check_field("unknown_opcode", 32'(s.unknown), 32'(rsp_unknown_opcode));
         end
         n_got++;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("cpu_instruction_subset_executor_tb failed");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_mode = MODE_EXEC;
      req_address = 16'd0;
      req_write_data = 8'd0;
      rsp_ready = 1'b0;
      build_stimulus();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      while (pending_words.size() > 0 || req_valid || expected_snaps.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (expected_snaps.size() > 0) begin
         $error("%0d response words never arrived", expected_snaps.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("cpu_instruction_subset_executor_tb passed");
      end else begin
         $display("cpu_instruction_subset_executor_tb failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
design/cise_pkg.sv
design/cise_queue.sv
design/cise_exec.sv
design/cpu_instruction_subset_executor.sv
tb/cpu_instruction_subset_executor_tb.sv
